>>> hw/rtl/sha1_pkg.sv
`timescale 1ns / 1ps

package sha1_pkg;

  typedef enum logic [2:0] {
    S_IN,
    S_PADSET,
    S_PAD,
    S_CRD,
    S_CRUN,
    S_CADD,
    S_OUT
  } state_t;

  localparam int unsigned ROUNDS = 80;
  localparam int unsigned WIN_DEPTH = 16;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  localparam logic [7:0] PAD_MARK = 8'h80;

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20) begin
      k = 32'h5A827999;
    end else if (r < 7'd40) begin
      k = 32'h6ED9EBA1;
    end else if (r < 7'd60) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20) begin
      f = d ^ (b & (c ^ d));
    end else if (r < 7'd40) begin
      f = b ^ c ^ d;
    end else if (r < 7'd60) begin
      f = (b & c) | (d & (b | c));
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

>>> hw/rtl/sha1_message_hash.sv
`timescale 1ns / 1ps
// Closing: a last word is followed by a set-up state, pad writes into the block memory,
//   compression and an output state; a second block is padded and compressed when the
//   length field does not fit, and the output state waits until the previous digest drains.
// Throughput: one byte word per cycle while filling; each full 64-byte block is then
//   compressed at one round per cycle from the 16-word block memory and schedule window, input held off.
// Reset: synchronous; restores the initial chaining value, clears counts and output valid.
module sha1_message_hash (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic         s_tuser,   // byte_present
  input  logic         s_tlast,   // last
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata    // digest_word_0 .. digest_word_4, lowest bits first
);
  import sha1_pkg::*;

  state_t state, state_next;

  logic [31:0] mem [WIN_DEPTH];
  logic        mem_we;
  logic [3:0]  mem_waddr;
  logic [31:0] mem_wdata;
  logic [3:0]  mem_raddr;
  logic [31:0] mem_rdata;

  logic [31:0] h0, h1, h2, h3, h4;
  logic [31:0] a, b, c, d, e;
  logic [31:0] win [WIN_DEPTH];
  logic [6:0]  rnd;
  logic [5:0]  fill;
  logic [63:0] bit_count;
  logic [23:0] acc;
  logic        last_pend;
  logic        final_ph;
  logic        two_blk;
  logic        pad_mark;
  logic        pad_len;
  logic [3:0]  pad_idx;

  logic        in_acc;
  logic        out_free;
  logic [31:0] pad_word;
  logic [31:0] w_sched;
  logic [31:0] w_cur;
  logic [31:0] t_sum;

  assign s_tready = (state == S_IN);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    if (pad_mark) begin
      unique case (fill[1:0])
        2'd0: pad_word = {PAD_MARK, 24'h0};
        2'd1: pad_word = {acc[7:0], PAD_MARK, 16'h0};
        2'd2: pad_word = {acc[15:0], PAD_MARK, 8'h0};
        2'd3: pad_word = {acc[23:0], PAD_MARK};
      endcase
    end else if (pad_len && pad_idx == 4'd14) begin
      pad_word = bit_count[63:32];
    end else if (pad_len && pad_idx == 4'd15) begin
      pad_word = bit_count[31:0];
    end else begin
      pad_word = 32'h0;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pad_idx;
    mem_wdata = pad_word;
    if (state == S_IN) begin
      mem_we    = in_acc && s_tuser && (fill[1:0] == 2'd3);
      mem_waddr = fill[5:2];
      mem_wdata = {acc, s_tdata};
    end else if (state == S_PAD) begin
      mem_we = 1'b1;
    end
    mem_raddr = (state == S_CRUN) ? rnd[3:0] + 4'd1 : 4'd0;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  assign w_sched = win[13] ^ win[8] ^ win[2] ^ win[0];
  assign w_cur   = (rnd < 7'd16) ? mem_rdata : {w_sched[30:0], w_sched[31]};
  assign t_sum   = {a[26:0], a[31:27]} + round_f(rnd, b, c, d) + e + w_cur + round_k(rnd);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IN: begin
        if (in_acc) begin
          if (s_tuser && fill == 6'd63) begin
            state_next = S_CRD;
          end else if (s_tlast) begin
            state_next = S_PADSET;
          end
        end
      end
      S_PADSET: state_next = S_PAD;
      S_PAD: begin
        if (pad_idx == 4'd15) begin
          state_next = S_CRD;
        end
      end
      S_CRD: state_next = S_CRUN;
      S_CRUN: begin
        if (rnd == 7'(ROUNDS - 1)) begin
          state_next = S_CADD;
        end
      end
      S_CADD: begin
        if (final_ph) begin
          state_next = two_blk ? S_PAD : S_OUT;
        end else begin
          state_next = last_pend ? S_PADSET : S_IN;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IN;
        end
      end
      default: state_next = S_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h0        <= H0_INIT;
      h1        <= H1_INIT;
      h2        <= H2_INIT;
      h3        <= H3_INIT;
      h4        <= H4_INIT;
      fill      <= 6'd0;
      bit_count <= 64'd0;
      final_ph  <= 1'b0;
      last_pend <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IN: begin
          if (in_acc) begin
            last_pend <= s_tlast;
            if (s_tuser) begin
              fill      <= fill + 6'd1;
              bit_count <= bit_count + 64'd8;
            end
          end
        end
        S_PADSET: final_ph <= 1'b1;
        S_CADD: begin
          h0 <= h0 + a;
          h1 <= h1 + b;
          h2 <= h2 + c;
          h3 <= h3 + d;
          h4 <= h4 + e;
        end
        S_OUT: begin
          if (out_free) begin
            h0        <= H0_INIT;
            h1        <= H1_INIT;
            h2        <= H2_INIT;
            h3        <= H3_INIT;
            h4        <= H4_INIT;
            fill      <= 6'd0;
            bit_count <= 64'd0;
            final_ph  <= 1'b0;
            last_pend <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IN: begin
        if (in_acc && s_tuser) begin
          acc <= {acc[15:0], s_tdata};
        end
      end
      S_PADSET: begin
        pad_idx  <= fill[5:2];
        pad_mark <= 1'b1;
        two_blk  <= (fill[5:3] == 3'd7);
        pad_len  <= (fill[5:3] != 3'd7);
      end
      S_PAD: begin
        pad_mark <= 1'b0;
        pad_idx  <= pad_idx + 4'd1;
      end
      S_CRD: begin
        a   <= h0;
        b   <= h1;
        c   <= h2;
        d   <= h3;
        e   <= h4;
        rnd <= 7'd0;
      end
      S_CRUN: begin
        a   <= t_sum;
        b   <= a;
        c   <= {b[1:0], b[31:2]};
        d   <= c;
        e   <= d;
        rnd <= rnd + 7'd1;
        for (int k = 0; k < WIN_DEPTH - 1; k++) begin
          win[k] <= win[k + 1];
        end
        win[WIN_DEPTH - 1] <= w_cur;
      end
      S_CADD: begin
        if (final_ph && two_blk) begin
          two_blk  <= 1'b0;
          pad_idx  <= 4'd0;
          pad_mark <= 1'b0;
          pad_len  <= 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          m_tdata <= {h4, h3, h2, h1, h0};
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_cadd_after_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_CADD) |-> ($past(state) == S_CRUN && $past(rnd) == 7'(ROUNDS - 1)))
    else $error("compression finished before all rounds ran");

  a_valid_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_OUT))
    else $error("digest raised outside the output state");

  a_no_input_in_final: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !final_ph)
    else $error("input taken while a message is being closed");

  a_pad_ends_at_top: assert property (@(posedge clk) disable iff (rst)
    (state == S_PAD && state_next == S_CRD) |-> (pad_idx == 4'd15))
    else $error("padding sweep left the block incomplete");
`endif

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } hash_word_t;

  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_CYCLES = 200;
  localparam int PHASE_WORDS = 580;

  localparam logic [31:0] CHAIN_IV [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                          32'h10325476, 32'hC3D2E1F0};
  localparam logic [31:0] ROUND_K [4] = '{32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC,
                                         32'hCA62C1D6};
  localparam logic [7:0] PAD_BYTE = 8'h80;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'h00;  // data_byte
  logic         s_tuser = 1'b0;   // byte_present
  logic         s_tlast = 1'b0;   // last
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [159:0] m_tdata;          // digest_word_0 .. digest_word_4

  sha1_message_hash uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  hash_word_t     pending_words[$];
  logic [159:0]   digest_q[$];
  int unsigned    words_sent = 0;
  int unsigned    words_taken = 0;
  int unsigned    src_gap_pct = 23;
  int unsigned    sink_stall_pct = 45;
  int unsigned    mismatches = 0;
  int unsigned    digests_checked = 0;
  int unsigned    idle_cycles = 0;

  // predictor state
  logic [31:0]    hash_h[5];
  logic [7:0]     msg_buf[64];
  int unsigned    buf_fill;
  logic [63:0]    msg_bits;
  int unsigned    msgs_closed = 0;
  int unsigned    bytes_hashed = 0;
  int unsigned    double_pads = 0;
  int unsigned    empty_words = 0;

  function automatic void restart_message();
    for (int i = 0; i < 5; i++) hash_h[i] = CHAIN_IV[i];
    buf_fill = 0;
    msg_bits = '0;
  endfunction

  function automatic void compress_buffer();
    logic [31:0] w[16];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    int s;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_buf[4*i], msg_buf[4*i+1], msg_buf[4*i+2], msg_buf[4*i+3]};
    a = hash_h[0];
    b = hash_h[1];
    c = hash_h[2];
    d = hash_h[3];
    e = hash_h[4];
    for (int r = 0; r < 80; r++) begin
      s = r % 16;
      if (r >= 16) begin
        x = w[(s+13)%16] ^ w[(s+8)%16] ^ w[(s+2)%16] ^ w[s];
        w[s] = {x[30:0], x[31]};
      end
      case (r / 20)
        0: f = (b & c) | (~b & d);
        2: f = (b & c) | (b & d) | (c & d);
        default: f = b ^ c ^ d;
      endcase
      k = ROUND_K[r / 20];
      t = {a[26:0], a[31:27]} + f + e + w[s] + k;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_h[0] += a;
    hash_h[1] += b;
    hash_h[2] += c;
    hash_h[3] += d;
    hash_h[4] += e;
  endfunction

  function automatic bit absorb_word(input hash_word_t wd, output logic [159:0] digest);
    int n;
    digest = '0;
    if (wd.present) begin
      msg_buf[buf_fill] = wd.data;
      buf_fill++;
      msg_bits += 64'd8;
      bytes_hashed++;
      if (buf_fill == 64) begin
        compress_buffer();
        buf_fill = 0;
      end
    end
    if (!wd.last) return 1'b0;
    n = buf_fill;
    msg_buf[n] = PAD_BYTE;
    n++;
    for (int i = n; i < 64; i++) msg_buf[i] = 8'h00;
    if (n > 56) begin
      compress_buffer();
      for (int i = 0; i < 64; i++) msg_buf[i] = 8'h00;
      double_pads++;
    end
    for (int i = 0; i < 8; i++) msg_buf[56+i] = msg_bits[63-8*i -: 8];
    compress_buffer();
    for (int i = 0; i < 5; i++) digest[32*i +: 32] = hash_h[i];
    msgs_closed++;
    restart_message();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch %s: got %08h, want %08h", $time, what, got, want);
    mismatches++;
  endtask

  initial restart_message();

  // drive
  always @(negedge clk) begin : drive
    hash_word_t wd;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || words_taken == words_sent) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= src_gap_pct) begin
        wd = pending_words.pop_front();
        s_tdata <= wd.data;
        s_tuser <= wd.present;
        s_tlast <= wd.last;
        s_tvalid <= 1'b1;
        words_sent <= words_sent + 1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // observe
  always @(posedge clk) begin : observe
    hash_word_t wd;
    logic [159:0] digest;
    logic [159:0] want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        wd.data = s_tdata;
        wd.present = s_tuser;
        wd.last = s_tlast;
        if (!wd.present && !wd.last) empty_words++;
        if (absorb_word(wd, digest)) digest_q.push_back(digest);
        words_taken <= words_taken + 1;
      end
      if (m_tvalid && m_tready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: digest with none pending: %040h", $time, m_tdata);
          mismatches++;
        end else begin
          want = digest_q.pop_front();
          for (int i = 0; i < 5; i++)
            if (m_tdata[32*i +: 32] !== want[32*i +: 32])
              report_mismatch($sformatf("digest word %0d", i), m_tdata[32*i +: 32],
                              want[32*i +: 32]);
          digests_checked++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", idle_cycles);
      $display("sha1_message_hash verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic hash_word_t make_word(input bit present, input bit last);
    hash_word_t wd;
    wd.data = 8'($urandom_range(255));
    wd.present = present;
    wd.last = last;
    return wd;
  endfunction

  function automatic int pick_length();
    int sel;
    int edges[12] = '{54, 55, 56, 57, 62, 63, 64, 65, 119, 120, 127, 128};
    sel = $urandom_range(99);
    if (sel < 40) return $urandom_range(8);
    if (sel < 70) return edges[$urandom_range(11)];
    return $urandom_range(130);
  endfunction

  // queue one message; returns the words queued
  function automatic int queue_message(input int len, input bit noisy);
    int n;
    bit close_on_byte;
    n = 0;
    close_on_byte = (len > 0) && $urandom_range(1);
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(19) == 0) begin
        pending_words.push_back(make_word(1'b0, 1'b0));
        n++;
      end
      pending_words.push_back(make_word(1'b1, close_on_byte && i == len - 1));
      n++;
    end
    if (!close_on_byte) begin
      pending_words.push_back(make_word(1'b0, 1'b1));
      n++;
    end
    return n;
  endfunction

  task automatic drain_sender();
    while (pending_words.size() > 0 || words_taken != words_sent) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned gap, input int unsigned stall);
    int count;
    src_gap_pct = gap;
    sink_stall_pct = stall;
    count = 0;
    while (count < PHASE_WORDS) count += queue_message(pick_length(), 1'b1);
    drain_sender();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty message, then an ignored word
    pending_words.push_back(hash_word_t'{data: 8'hA5, present: 1'b0, last: 1'b1});
    pending_words.push_back(hash_word_t'{data: 8'h5A, present: 1'b0, last: 1'b0});
    // "abc" closed on its last byte
    pending_words.push_back(hash_word_t'{data: 8'h61, present: 1'b1, last: 1'b0});
    pending_words.push_back(hash_word_t'{data: 8'h62, present: 1'b1, last: 1'b0});
    pending_words.push_back(hash_word_t'{data: 8'h63, present: 1'b1, last: 1'b1});
    // extreme bytes
    pending_words.push_back(hash_word_t'{data: 8'h00, present: 1'b1, last: 1'b1});
    pending_words.push_back(hash_word_t'{data: 8'hFF, present: 1'b1, last: 1'b0});
    pending_words.push_back(hash_word_t'{data: 8'hFF, present: 1'b0, last: 1'b1});
    // gap words inside a message
    pending_words.push_back(hash_word_t'{data: 8'h80, present: 1'b1, last: 1'b0});
    pending_words.push_back(hash_word_t'{data: 8'h00, present: 1'b0, last: 1'b0});
    pending_words.push_back(hash_word_t'{data: 8'h7F, present: 1'b1, last: 1'b0});
    pending_words.push_back(hash_word_t'{data: 8'hFF, present: 1'b0, last: 1'b0});
    pending_words.push_back(hash_word_t'{data: 8'h55, present: 1'b1, last: 1'b0});
    pending_words.push_back(hash_word_t'{data: 8'hAA, present: 1'b1, last: 1'b1});
    // two empty messages back to back
    pending_words.push_back(hash_word_t'{data: 8'h00, present: 1'b0, last: 1'b1});
    pending_words.push_back(hash_word_t'{data: 8'hFF, present: 1'b0, last: 1'b1});

    run_phase(23, 45);
    run_phase(45, 23);
    run_phase(0, 0);

    while (digest_q.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("hashed %0d messages, %0d bytes, %0d needing a second pad block",
             msgs_closed, bytes_hashed, double_pads);
    $display("%0d digests checked, %0d words ignored, %0d mismatches",
             digests_checked, empty_words, mismatches);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("sha1_message_hash verification clean");
    end else begin
      $display("sha1_message_hash verification failed");
    end
    $finish;
  end

endmodule
